// File: rtl/ptng_pkg.sv
`timescale 1ns / 1ps

package ptng_pkg;

    // Field types
    typedef logic [14:0]        pitch_t;    // unsigned Q7.8 MIDI pitch
    typedef logic [6:0]         note_t;     // MIDI note or velocity
    typedef logic signed [15:0] q88_t;      // signed Q8.8 level or measure
    typedef logic [1:0]         mode_t;

    // Result of one frame
    typedef struct packed {
        logic  send_event;
        note_t note_on;
        note_t note_on_velocity;
        note_t note_off;
    } result_t;

    // Gate modes
    localparam mode_t MODE_OFF    = 2'd0;
    localparam mode_t MODE_ON     = 2'd1;
    localparam mode_t MODE_RETRIG = 2'd2;
    localparam mode_t MODE_BEND   = 2'd3;

    // Register map, word index (byte address / 4)
    localparam int unsigned        PADDR_W      = 5;
    localparam logic [2:0] REG_RELEASE_LEVEL     = 3'd0;
    localparam logic [2:0] REG_NOISE_LEVEL       = 3'd1;
    localparam logic [2:0] REG_BEND_LIMIT        = 3'd2;
    localparam logic [2:0] REG_RETRIG_NEW_LIMIT  = 3'd3;
    localparam logic [2:0] REG_RETRIG_SAME_LIMIT = 3'd4;
    localparam logic [2:0] REG_BEND_ENABLE       = 3'd5;

    // Register reset values
    localparam q88_t RST_RELEASE_LEVEL     = -16'sd10240;
    localparam q88_t RST_NOISE_LEVEL       = -16'sd12800;
    localparam q88_t RST_BEND_LIMIT        = 16'sd256;
    localparam q88_t RST_RETRIG_NEW_LIMIT  = 16'sd0;
    localparam q88_t RST_RETRIG_SAME_LIMIT = 16'sd0;

    localparam note_t NOTE_MAX = 7'd127;

    // Round a Q7.8 pitch half up to a note, saturating at the top note
    function automatic note_t to_note(input pitch_t p);
        logic [15:0] sum;
        logic [7:0]  n;
        sum = {1'b0, p} + 16'd128;
        n   = sum[15:8];
        return n[7] ? NOTE_MAX : n[6:0];
    endfunction

endpackage

// File: rtl/pitch_to_note_gate.sv
`timescale 1ns / 1ps

// Note gate: one analysis frame per transaction in, one note result per transaction
// out. Sustained rate is one frame per clock while out_ready is held high; a frame
// passes through the input register and then the result register. The mode and pitch
// history update closes combinationally between those registers, which is what lets a
// frame follow in the very next cycle. A frame waits in the input register while
// a finished result is held for the downstream side. Configuration goes through
// an APB-style port at byte addresses 4*i and should be written while idle.
module pitch_to_note_gate (
    input  logic                       clk,
    input  logic                       rst_n,

    // Frame input
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ptng_pkg::pitch_t           pitch_in,
    input  ptng_pkg::note_t            velocity_in,
    input  ptng_pkg::q88_t             level_db,
    input  ptng_pkg::q88_t             freq_change,
    input  ptng_pkg::q88_t             retrig_measure,
    input  logic                       pitch_stable,

    // Note result
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       send_event,
    output ptng_pkg::note_t            note_on,
    output ptng_pkg::note_t            note_on_velocity,
    output ptng_pkg::note_t            note_off,

    // Configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ptng_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    import ptng_pkg::*;

    // Configuration registers
    q88_t       release_level_reg;
    q88_t       noise_level_reg;
    q88_t       bend_limit_reg;
    q88_t       retrig_new_limit_reg;
    q88_t       retrig_same_limit_reg;
    logic       bend_enable_reg;
    logic [2:0] reg_index;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_level_reg     <= RST_RELEASE_LEVEL;
            noise_level_reg       <= RST_NOISE_LEVEL;
            bend_limit_reg        <= RST_BEND_LIMIT;
            retrig_new_limit_reg  <= RST_RETRIG_NEW_LIMIT;
            retrig_same_limit_reg <= RST_RETRIG_SAME_LIMIT;
            bend_enable_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_RELEASE_LEVEL:     release_level_reg     <= pwdata[15:0];
                REG_NOISE_LEVEL:       noise_level_reg       <= pwdata[15:0];
                REG_BEND_LIMIT:        bend_limit_reg        <= pwdata[15:0];
                REG_RETRIG_NEW_LIMIT:  retrig_new_limit_reg  <= pwdata[15:0];
                REG_RETRIG_SAME_LIMIT: retrig_same_limit_reg <= pwdata[15:0];
                REG_BEND_ENABLE:       bend_enable_reg       <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback, signed values sign-extended
    always_comb
    begin
        case (reg_index)
            REG_RELEASE_LEVEL:     prdata = {{16{release_level_reg[15]}}, release_level_reg};
            REG_NOISE_LEVEL:       prdata = {{16{noise_level_reg[15]}}, noise_level_reg};
            REG_BEND_LIMIT:        prdata = {{16{bend_limit_reg[15]}}, bend_limit_reg};
            REG_RETRIG_NEW_LIMIT:
                prdata = {{16{retrig_new_limit_reg[15]}}, retrig_new_limit_reg};
            REG_RETRIG_SAME_LIMIT:
                prdata = {{16{retrig_same_limit_reg[15]}}, retrig_same_limit_reg};
            REG_BEND_ENABLE:       prdata = {31'b0, bend_enable_reg};
            default:               prdata = 32'b0;
        endcase
    end

    // Pipeline handshake
    logic    s1_valid_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_accept;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Input register
    pitch_t s1_pitch_reg;
    note_t  s1_velocity_reg;
    q88_t   s1_level_reg;
    q88_t   s1_dfreq_reg;
    q88_t   s1_retrig_reg;
    logic   s1_stable_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pitch_reg    <= pitch_in;
            s1_velocity_reg <= velocity_in;
            s1_level_reg    <= level_db;
            s1_dfreq_reg    <= freq_change;
            s1_retrig_reg   <= retrig_measure;
            s1_stable_reg   <= pitch_stable;
        end
    end

    // Gate state
    mode_t  mode_reg, mode_next;
    pitch_t prev_pitch_reg, prev_pitch_next;
    pitch_t cur_pitch_reg, cur_pitch_next;
    result_t result_reg, result_next;

    logic differs;
    logic both_zero;
    logic released;

    assign differs   = cur_pitch_reg != s1_pitch_reg;
    assign both_zero = (to_note(prev_pitch_reg) == 7'd0) && (to_note(cur_pitch_reg) == 7'd0);
    assign released  = s1_level_reg < release_level_reg;

    // Mode update and note selection for the frame in the input register
    always_comb
    begin
        mode_next       = mode_reg;
        prev_pitch_next = prev_pitch_reg;
        cur_pitch_next  = cur_pitch_reg;
        result_next     = '0;

        case (mode_reg)
            MODE_ON:
            begin
                if (released)
                    mode_next = MODE_OFF;
                else if (differs && s1_stable_reg && bend_enable_reg &&
                         (s1_dfreq_reg < bend_limit_reg))
                    mode_next = (s1_retrig_reg < retrig_same_limit_reg) ? MODE_RETRIG
                                                                         : MODE_BEND;
                else if (((s1_retrig_reg < retrig_new_limit_reg) && differs &&
                          !bend_enable_reg) ||
                         ((s1_retrig_reg < retrig_same_limit_reg) && !differs))
                    mode_next = MODE_RETRIG;
                else if (differs && s1_stable_reg)
                begin
                    prev_pitch_next              = cur_pitch_reg;
                    cur_pitch_next               = s1_pitch_reg;
                    result_next.send_event       = 1'b1;
                    result_next.note_on          = to_note(s1_pitch_reg);
                    result_next.note_on_velocity = s1_velocity_reg;
                    result_next.note_off         = to_note(cur_pitch_reg);
                end
            end
            MODE_RETRIG:
            begin
                if (!both_zero)
                begin
                    result_next.send_event = 1'b1;
                    result_next.note_off   = to_note(prev_pitch_reg);
                    prev_pitch_next        = cur_pitch_reg;
                    cur_pitch_next         = '0;
                end
                else
                    mode_next = MODE_OFF;
            end
            MODE_BEND:
            begin
                if (released)
                    mode_next = MODE_OFF;
                else if (s1_dfreq_reg > bend_limit_reg)
                    mode_next = MODE_RETRIG;
            end
            default:
            begin
                // Flush any held note before a new one may start
                if (!both_zero)
                begin
                    result_next.send_event = 1'b1;
                    result_next.note_off   = to_note(prev_pitch_reg);
                    prev_pitch_next        = cur_pitch_reg;
                    cur_pitch_next         = '0;
                end
                else if ((s1_level_reg > noise_level_reg) && (s1_pitch_reg != '0) &&
                         s1_stable_reg)
                begin
                    prev_pitch_next              = cur_pitch_reg;
                    cur_pitch_next               = s1_pitch_reg;
                    result_next.send_event       = 1'b1;
                    result_next.note_on          = to_note(s1_pitch_reg);
                    result_next.note_on_velocity = s1_velocity_reg;
                    result_next.note_off         = to_note(cur_pitch_reg);
                    mode_next                    = MODE_ON;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_OFF;
            prev_pitch_reg <= '0;
            cur_pitch_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            prev_pitch_reg <= prev_pitch_next;
            cur_pitch_reg  <= cur_pitch_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid        = out_valid_reg;
    assign send_event       = result_reg.send_event;
    assign note_on          = result_reg.note_on;
    assign note_on_velocity = result_reg.note_on_velocity;
    assign note_off         = result_reg.note_off;

    // Checks
    a_quiet_result_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.send_event |->
            (result_reg.note_on == 7'd0) && (result_reg.note_on_velocity == 7'd0) &&
            (result_reg.note_off == 7'd0))
        else $error("quiet result carries a nonzero note field");

    a_bend_never_sends: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (mode_reg == MODE_BEND) |=> out_valid_reg && !result_reg.send_event)
        else $error("bend mode emitted a note message");

    a_retrig_exit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (mode_reg == MODE_RETRIG) |=>
            (mode_reg == MODE_RETRIG) || (mode_reg == MODE_OFF))
        else $error("retrigger left to a mode other than off");

    a_note_start_sends: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (mode_reg == MODE_OFF) && (mode_next == MODE_ON) |=>
            out_valid_reg && result_reg.send_event &&
            (result_reg.note_on_velocity == $past(s1_velocity_reg)))
        else $error("note start without a note-on transaction");

    a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(mode_reg) && $stable(cur_pitch_reg) && $stable(prev_pitch_reg))
        else $error("gate state changed without a frame");

endmodule
